>>> hdl/polar_rect_vector_converter_core_macros.svh
// ----------------------------------------------------------------------------
// polar_rect_vector_converter_core_macros
// assertion macros shared by the converter core, clocked on clk_i and held
// off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef POLAR_RECT_VECTOR_CONVERTER_CORE_MACROS_SVH
`define POLAR_RECT_VECTOR_CONVERTER_CORE_MACROS_SVH

// same-cycle implication
`define PRCV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PRCV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/prcv_pkg.sv
// ----------------------------------------------------------------------------
// prcv_pkg
// types, widths and constants of the polar/rectangular vector converter
// ----------------------------------------------------------------------------
package prcv_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned GUARD      = 8;
  localparam int unsigned TABLE_LEN  = 24;

  localparam int unsigned SPD_W  = 32;
  localparam int unsigned MAG_W  = 31;
  localparam int unsigned BRG_W  = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned DP_W   = 44;
  localparam int unsigned Z_W    = 32;

  localparam int unsigned KINV_W    = 20;
  localparam int unsigned KINV_FRAC = 20;
  localparam logic [KINV_W-1:0] KINV_Q20 = 20'd636751;

  // round(0.001 m/s) in speed lsbs
  localparam logic [CFG_W-1:0] DEAD_ZONE_RESET =
    CFG_W'(((2 ** FRAC_BITS) + 500) / 1000);

  localparam logic [BRG_W-1:0] QUARTER_TURN       = BRG_W'(1 << (ANGLE_BITS - 2));
  localparam logic [BRG_W-1:0] THREE_QUARTER_TURN = BRG_W'(3 << (ANGLE_BITS - 2));
  localparam logic [Z_W-1:0]   HALF_TURN          = Z_W'(1) << (Z_W - 1);

  // arctan(2^-i) as a fraction of a turn
  localparam logic [Z_W-1:0] ATAN_TURN [TABLE_LEN] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  typedef enum logic {
    FUNC_P2R = 1'b0,
    FUNC_R2P = 1'b1
  } func_e;

  typedef struct packed {
    func_e                   func;
    logic signed [SPD_W-1:0] along_in;
    logic signed [SPD_W-1:0] across_in;
    logic [BRG_W-1:0]        bearing_in;
    logic [MAG_W-1:0]        magnitude_in;
  } in_t;

  typedef struct packed {
    logic signed [SPD_W-1:0] along_out;
    logic signed [SPD_W-1:0] across_out;
    logic [BRG_W-1:0]        bearing_out;
    logic [MAG_W-1:0]        magnitude_out;
    logic                    dead_zone_hit;
  } out_t;

  typedef struct packed {
    in_t                    req;
    logic                   hit;
    logic signed [DP_W-1:0] x;
    logic signed [DP_W-1:0] y;
    logic [Z_W-1:0]         z;
  } cordic_t;

endpackage

>>> hdl/prcv_pre.sv
// ----------------------------------------------------------------------------
// prcv_pre
// two entry stages: gain-corrected magnitude product and dead zone test,
// then quadrant fold and start vector of the cordic
// ----------------------------------------------------------------------------
module prcv_pre (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [prcv_pkg::CFG_W-1:0]        dead_zone_i,
  input  logic                              valid_i,
  input  prcv_pkg::in_t                     req_i,
  output logic                              ready_o,
  output logic                              valid_o,
  output prcv_pkg::cordic_t                 data_o,
  input  logic                              ready_i
);

  localparam int unsigned PROD_W = prcv_pkg::MAG_W + prcv_pkg::KINV_W;
  localparam int unsigned M_SH   = prcv_pkg::KINV_FRAC - prcv_pkg::GUARD;

  logic                              a_valid_q;
  prcv_pkg::in_t                     a_req_q;
  logic [PROD_W-1:0]                 a_prod_q, a_prod_d;
  logic                              a_hit_q, a_hit_d;
  logic                              a_ready;

  logic                              b_valid_q;
  prcv_pkg::cordic_t                 b_data_q, b_data_d;
  logic                              b_ready;

  logic [prcv_pkg::SPD_W-1:0]        abs_along;
  logic signed [prcv_pkg::DP_W-1:0]  mag_x;
  logic signed [prcv_pkg::DP_W-1:0]  along_x;
  logic signed [prcv_pkg::DP_W-1:0]  across_x;
  logic [prcv_pkg::Z_W-1:0]          z_fold;
  logic                              flip;

  assign b_ready = ~b_valid_q | ready_i;
  assign a_ready = ~a_valid_q | b_ready;
  assign ready_o = a_ready;
  assign valid_o = b_valid_q;
  assign data_o  = b_data_q;

  // stage a
  always_comb begin
    abs_along = req_i.along_in[prcv_pkg::SPD_W-1] ?
                prcv_pkg::SPD_W'(-req_i.along_in) : prcv_pkg::SPD_W'(req_i.along_in);
    a_hit_d   = abs_along <= prcv_pkg::SPD_W'(dead_zone_i);
    a_prod_d  = PROD_W'(req_i.magnitude_in) * PROD_W'(prcv_pkg::KINV_Q20)
              + PROD_W'(1 << (M_SH - 1));
  end

  // stage b
  always_comb begin
    mag_x    = prcv_pkg::DP_W'(a_prod_q[PROD_W-1:M_SH]);
    along_x  = prcv_pkg::DP_W'(a_req_q.along_in) <<< prcv_pkg::GUARD;
    across_x = prcv_pkg::DP_W'(a_req_q.across_in) <<< prcv_pkg::GUARD;
    z_fold   = prcv_pkg::Z_W'(a_req_q.bearing_in) << (prcv_pkg::Z_W - prcv_pkg::ANGLE_BITS);
    flip     = z_fold[prcv_pkg::Z_W-1] ^ z_fold[prcv_pkg::Z_W-2];

    b_data_d     = '0;
    b_data_d.req = a_req_q;
    b_data_d.hit = a_hit_q;
    case (a_req_q.func)
      prcv_pkg::FUNC_P2R: begin
        b_data_d.x = flip ? -mag_x : mag_x;
        b_data_d.y = '0;
        b_data_d.z = flip ? (z_fold ^ prcv_pkg::HALF_TURN) : z_fold;
      end
      prcv_pkg::FUNC_R2P: begin
        if (a_req_q.along_in[prcv_pkg::SPD_W-1]) begin
          b_data_d.x = -along_x;
          b_data_d.y = -across_x;
          b_data_d.z = prcv_pkg::HALF_TURN;
        end else begin
          b_data_d.x = along_x;
          b_data_d.y = across_x;
          b_data_d.z = '0;
        end
      end
      default: begin
        b_data_d.x = '0;
        b_data_d.y = '0;
        b_data_d.z = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_req_q  <= req_i;
      a_prod_q <= a_prod_d;
      a_hit_q  <= a_hit_d;
    end
    if (b_ready && a_valid_q) begin
      b_data_q <= b_data_d;
    end
  end

endmodule

>>> hdl/prcv_stage.sv
// ----------------------------------------------------------------------------
// prcv_stage
// one registered cordic micro-rotation, rotation or vectoring by mode
// ----------------------------------------------------------------------------
module prcv_stage #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  prcv_pkg::cordic_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output prcv_pkg::cordic_t data_o,
  input  logic              ready_i
);

  localparam logic [prcv_pkg::Z_W-1:0] ANGLE = prcv_pkg::ATAN_TURN[IDX];

  logic                             valid_q;
  prcv_pkg::cordic_t                data_q, data_d;
  logic signed [prcv_pkg::DP_W-1:0] dx, dy;
  logic                             turn_pos;

  assign ready_o = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    dx = data_i.y >>> IDX;
    dy = data_i.x >>> IDX;
    // positive turn drives z toward zero (rotation) or y toward zero (vectoring)
    turn_pos = (data_i.req.func == prcv_pkg::FUNC_P2R) ?
               ~data_i.z[prcv_pkg::Z_W-1] : data_i.y[prcv_pkg::DP_W-1];
    data_d = data_i;
    if (turn_pos) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ANGLE;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> hdl/prcv_post.sv
// ----------------------------------------------------------------------------
// prcv_post
// two exit stages: rounding and saturation of the components, bearing
// rounding and dead zone override, split gain-correction product; then the
// magnitude sum and the result register
// ----------------------------------------------------------------------------
module prcv_post (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  prcv_pkg::cordic_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output prcv_pkg::out_t    res_o,
  input  logic              ready_i
);

  localparam int unsigned LO_W   = 21;
  localparam int unsigned HI_W   = prcv_pkg::DP_W - 1 - LO_W;
  localparam int unsigned PL_W   = LO_W + prcv_pkg::KINV_W;
  localparam int unsigned PH_W   = HI_W + prcv_pkg::KINV_W;
  localparam int unsigned SUM_W  = PH_W + LO_W + 1;
  localparam int unsigned M_SH   = prcv_pkg::KINV_FRAC + prcv_pkg::GUARD;
  localparam int unsigned M_W    = SUM_W - M_SH;

  logic                             c_valid_q;
  prcv_pkg::in_t                    c_req_q;
  logic                             c_hit_q;
  logic signed [prcv_pkg::SPD_W-1:0] c_along_q, c_along_d;
  logic signed [prcv_pkg::SPD_W-1:0] c_across_q, c_across_d;
  logic [prcv_pkg::BRG_W-1:0]       c_bearing_q, c_bearing_d;
  logic [PL_W-1:0]                  c_pl_q, c_pl_d;
  logic [PH_W-1:0]                  c_ph_q, c_ph_d;
  logic                             c_ready;

  logic                             d_valid_q;
  prcv_pkg::out_t                   d_res_q, d_res_d;
  logic                             d_ready;

  logic [prcv_pkg::Z_W-1:0]         z_rnd;
  logic [prcv_pkg::BRG_W-1:0]       brg_rnd;
  logic [SUM_W-1:0]                 mag_sum;
  logic [M_W-1:0]                   mag_full;
  logic [prcv_pkg::MAG_W-1:0]       mag_sat;

  function automatic logic signed [prcv_pkg::SPD_W-1:0] sat_spd(
    input logic signed [prcv_pkg::DP_W-1:0] v
  );
    logic signed [prcv_pkg::DP_W-1:0] r;
    r = (v + prcv_pkg::DP_W'(1 << (prcv_pkg::GUARD - 1))) >>> prcv_pkg::GUARD;
    if (&r[prcv_pkg::DP_W-1:prcv_pkg::SPD_W-1] || ~|r[prcv_pkg::DP_W-1:prcv_pkg::SPD_W-1]) begin
      return r[prcv_pkg::SPD_W-1:0];
    end
    return r[prcv_pkg::DP_W-1] ? {1'b1, {(prcv_pkg::SPD_W-1){1'b0}}}
                               : {1'b0, {(prcv_pkg::SPD_W-1){1'b1}}};
  endfunction

  assign d_ready = ~d_valid_q | ready_i;
  assign c_ready = ~c_valid_q | d_ready;
  assign ready_o = c_ready;
  assign valid_o = d_valid_q;
  assign res_o   = d_res_q;

  // stage c
  always_comb begin
    c_along_d  = sat_spd(data_i.x);
    c_across_d = sat_spd(data_i.y);
    z_rnd      = data_i.z + (prcv_pkg::Z_W'(1) << (prcv_pkg::Z_W - 1 - prcv_pkg::ANGLE_BITS));
    brg_rnd    = prcv_pkg::BRG_W'(z_rnd >> (prcv_pkg::Z_W - prcv_pkg::ANGLE_BITS));
    if (data_i.req.func == prcv_pkg::FUNC_P2R) begin
      c_bearing_d = data_i.req.bearing_in;
    end else if (data_i.hit) begin
      c_bearing_d = data_i.req.across_in[prcv_pkg::SPD_W-1] ?
                    prcv_pkg::THREE_QUARTER_TURN : prcv_pkg::QUARTER_TURN;
    end else begin
      c_bearing_d = brg_rnd;
    end
    // x is never negative after vectoring
    c_pl_d = PL_W'(data_i.x[LO_W-1:0]) * PL_W'(prcv_pkg::KINV_Q20);
    c_ph_d = PH_W'(data_i.x[prcv_pkg::DP_W-2:LO_W]) * PH_W'(prcv_pkg::KINV_Q20);
  end

  // stage d
  always_comb begin
    mag_sum  = (SUM_W'(c_ph_q) << LO_W) + SUM_W'(c_pl_q) + (SUM_W'(1) << (M_SH - 1));
    mag_full = mag_sum[SUM_W-1:M_SH];
    mag_sat  = (|mag_full[M_W-1:prcv_pkg::MAG_W]) ? '1 : mag_full[prcv_pkg::MAG_W-1:0];
    d_res_d  = '0;
    case (c_req_q.func)
      prcv_pkg::FUNC_P2R: begin
        d_res_d.along_out     = c_along_q;
        d_res_d.across_out    = c_across_q;
        d_res_d.bearing_out   = c_bearing_q;
        d_res_d.magnitude_out = c_req_q.magnitude_in;
        d_res_d.dead_zone_hit = 1'b0;
      end
      prcv_pkg::FUNC_R2P: begin
        d_res_d.along_out     = c_req_q.along_in;
        d_res_d.across_out    = c_req_q.across_in;
        d_res_d.bearing_out   = c_bearing_q;
        d_res_d.magnitude_out = mag_sat;
        d_res_d.dead_zone_hit = c_hit_q;
      end
      default: begin
        d_res_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && valid_i) begin
      c_req_q     <= data_i.req;
      c_hit_q     <= data_i.hit;
      c_along_q   <= c_along_d;
      c_across_q  <= c_across_d;
      c_bearing_q <= c_bearing_d;
      c_pl_q      <= c_pl_d;
      c_ph_q      <= c_ph_d;
    end
    if (d_ready && c_valid_q) begin
      d_res_q <= d_res_d;
    end
  end

endmodule

>>> hdl/polar_rect_vector_converter_core.sv
// ----------------------------------------------------------------------------
// polar_rect_vector_converter_core
// Converts a Q15.16 velocity vector per request between bearing/magnitude and
// along/across components with an unrolled CORDIC pipeline. One request is
// taken every clock while in_stall_o is low; the pipeline is made of two entry
// stages, one register per CORDIC iteration and two exit stages. Each stage
// only holds when it is full and the stage after it holds, so output
// backpressure is absorbed by empty slots before in_stall_o rises.
// CORDIC_STAGES may be 8 to 24.
// ----------------------------------------------------------------------------
`include "polar_rect_vector_converter_core_macros.svh"

module polar_rect_vector_converter_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [prcv_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  prcv_pkg::in_t              in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output prcv_pkg::out_t             out_res_o
);

  logic [prcv_pkg::CFG_W-1:0] dead_zone_q;
  logic                       pre_ready;

  prcv_pkg::cordic_t          chain_data  [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0]     chain_valid;
  logic [CORDIC_STAGES:0]     chain_ready;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = ~pre_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= prcv_pkg::DEAD_ZONE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dead_zone_q <= cfg_data_i;
    end
  end

  prcv_pre u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dead_zone_i (dead_zone_q),
    .valid_i     (in_valid_i),
    .req_i       (in_req_i),
    .ready_o     (pre_ready),
    .valid_o     (chain_valid[0]),
    .data_o      (chain_data[0]),
    .ready_i     (chain_ready[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    prcv_stage #(
      .IDX (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .data_i  (chain_data[k]),
      .ready_o (chain_ready[k]),
      .valid_o (chain_valid[k+1]),
      .data_o  (chain_data[k+1]),
      .ready_i (chain_ready[k+1])
    );
  end

  prcv_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[CORDIC_STAGES]),
    .data_i  (chain_data[CORDIC_STAGES]),
    .ready_o (chain_ready[CORDIC_STAGES]),
    .valid_o (out_valid_o),
    .res_o   (out_res_o),
    .ready_i (~out_stall_i)
  );

  // input can only back up behind a waiting result
  `PRCV_ASSERT_NOW(a_stall_needs_result, in_stall_o, out_valid_o, "input stalled with empty output")

  `PRCV_ASSERT_NOW(a_hit_bearing, out_valid_o && out_res_o.dead_zone_hit, (out_res_o.bearing_out == prcv_pkg::QUARTER_TURN) || (out_res_o.bearing_out == prcv_pkg::THREE_QUARTER_TURN), "dead zone result without quarter bearing")

  `PRCV_ASSERT_NOW(a_hit_in_band, out_valid_o && out_res_o.dead_zone_hit, ($signed({out_res_o.along_out[31], out_res_o.along_out}) <= $signed({17'b0, dead_zone_q})) && ($signed({out_res_o.along_out[31], out_res_o.along_out}) >= -$signed({17'b0, dead_zone_q})), "dead zone flag outside band")

endmodule
